// ----- hw/rtl/drsd_pkg.sv -----
package drsd_pkg;

  localparam int unsigned MAP_ENTRIES = 4096;
  localparam int unsigned MAP_AW      = $clog2(MAP_ENTRIES);
  localparam int unsigned KEY_W       = 12;

  localparam logic [7:0]  HDR_TIME     = 8'h69;
  localparam logic [7:0]  HDR_HIT      = 8'h6a;
  localparam logic [2:0]  PAYLOAD_LAST = 3'd6;
  localparam logic [29:0] SEC_NS       = 30'd1000000000;
  localparam logic [19:0] MS_NS        = 20'd1000000;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  localparam logic CFG_LIMIT_EN = 1'b0;
  localparam logic CFG_LIMIT_NS = 1'b1;

  typedef enum logic [1:0] {
    KIND_MAPPED   = 2'd0,
    KIND_UNMAPPED = 2'd1,
    KIND_LIMIT    = 2'd2
  } result_kind_t;

  typedef struct packed {
    logic       mapped;
    logic [1:0] det_type;
    logic [7:0] strip;
  } map_entry_t;

  typedef struct packed {
    logic               vld;
    logic signed [24:0] diff;
    logic [19:0]        pw;
    logic [KEY_W-1:0]   key;
  } hit_req_t;

  typedef struct packed {
    result_kind_t     kind;
    logic [1:0]       det_type;
    logic [7:0]       strip;
    logic [3:0]       module_id;
    logic [KEY_W-1:0] channel_key;
    logic [63:0]      event_time_ns;
    logic [19:0]      pulse_width;
  } result_t;

endpackage

// ----- hw/rtl/drsd_chan_map.sv -----
module drsd_chan_map (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [drsd_pkg::MAP_AW-1:0] wr_addr,
  input  drsd_pkg::map_entry_t     wr_entry,
  input  logic [drsd_pkg::MAP_AW-1:0] rd_addr,
  output drsd_pkg::map_entry_t     rd_entry,
  output logic                     clearing
);

  drsd_pkg::map_entry_t mem [drsd_pkg::MAP_ENTRIES];

  logic                        clearing_r;
  logic [drsd_pkg::MAP_AW-1:0] clr_addr_r;
  drsd_pkg::map_entry_t        rd_entry_r;

  logic                        mem_we;
  logic [drsd_pkg::MAP_AW-1:0] mem_wa;
  drsd_pkg::map_entry_t        mem_wd;

  assign mem_we = clearing_r | wr_en;
  assign mem_wa = clearing_r ? clr_addr_r : wr_addr;
  assign mem_wd = clearing_r ? '0 : wr_entry;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_entry_r <= mem[rd_addr];
  end

  // clearing pass after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + drsd_pkg::MAP_AW'(1);
      if (clr_addr_r == drsd_pkg::MAP_AW'(drsd_pkg::MAP_ENTRIES - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign rd_entry = rd_entry_r;
  assign clearing = clearing_r;

endmodule

// ----- hw/rtl/drsd_parser.sv -----
module drsd_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        byte_acc,
  input  logic [7:0]                  byte_value,
  input  logic                        stopped,
  output logic                        hit_last,
  output logic [drsd_pkg::MAP_AW-1:0] map_rd_addr,
  output drsd_pkg::hit_req_t          hit_req,
  output logic [63:0]                 base_time
);

  typedef enum logic [1:0] {
    REC_HUNT = 2'd0,
    REC_TIME = 2'd1,
    REC_HIT  = 2'd2
  } rec_kind_t;

  rec_kind_t          kind_r, kind_nxt;
  logic [2:0]         pos_r, pos_nxt;
  logic [47:0]        rec_r, rec_nxt;
  logic               seen_r, seen_nxt;
  logic               tm_vld_r, tm_vld_nxt;
  logic [31:0]        sec_r;
  logic [9:0]         ms_r;
  drsd_pkg::hit_req_t hit_req_r, hit_req_nxt;

  logic               p_vld_r;
  logic [61:0]        psec_r;
  logic [29:0]        pms_r;
  logic [63:0]        base_r;
  logic [11:0]        full_key;

  assign full_key = {rec_r[3:0], byte_value};

  always_comb begin
    kind_nxt         = kind_r;
    pos_nxt          = pos_r;
    rec_nxt          = rec_r;
    seen_nxt         = seen_r;
    tm_vld_nxt       = 1'b0;
    hit_req_nxt.vld  = 1'b0;
    hit_req_nxt.diff = $signed({1'b0, rec_r[47:24]}) - $signed({5'd0, rec_r[23:4]});
    hit_req_nxt.pw   = rec_r[23:4];
    hit_req_nxt.key  = full_key;
    if (byte_acc) begin
      unique case (kind_r)
        REC_HUNT: begin
          if (byte_value == drsd_pkg::HDR_TIME) begin
            kind_nxt = REC_TIME;
            pos_nxt  = '0;
          end else if (byte_value == drsd_pkg::HDR_HIT && seen_r) begin
            kind_nxt = REC_HIT;
            pos_nxt  = '0;
          end
        end
        REC_TIME, REC_HIT: begin
          rec_nxt = {rec_r[39:0], byte_value};
          if (pos_r == drsd_pkg::PAYLOAD_LAST) begin
            kind_nxt = REC_HUNT;
            pos_nxt  = '0;
            if (kind_r == REC_TIME) begin
              tm_vld_nxt = 1'b1;
              seen_nxt   = 1'b1;
            end else begin
              hit_req_nxt.vld = 1'b1;
            end
          end else begin
            pos_nxt = pos_r + 3'd1;
          end
        end
        default: kind_nxt = REC_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r        <= REC_HUNT;
      pos_r         <= '0;
      seen_r        <= 1'b0;
      tm_vld_r      <= 1'b0;
      hit_req_r.vld <= 1'b0;
    end else begin
      kind_r        <= kind_nxt;
      pos_r         <= pos_nxt;
      seen_r        <= seen_nxt;
      tm_vld_r      <= tm_vld_nxt;
      hit_req_r.vld <= hit_req_nxt.vld;
    end
    rec_r          <= rec_nxt;
    sec_r          <= rec_r[47:16];
    ms_r           <= rec_r[15:6];
    hit_req_r.diff <= hit_req_nxt.diff;
    hit_req_r.pw   <= hit_req_nxt.pw;
    hit_req_r.key  <= hit_req_nxt.key;
  end

  // base time = seconds * 1e9 + ms * 1e6
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      base_r  <= '0;
    end else begin
      p_vld_r <= tm_vld_r;
      if (p_vld_r) begin
        base_r <= {2'b00, psec_r} + {34'd0, pms_r};
      end
    end
    psec_r <= {30'd0, sec_r} * {32'd0, drsd_pkg::SEC_NS};
    pms_r  <= {20'd0, ms_r} * {10'd0, drsd_pkg::MS_NS};
  end

  assign hit_last    = (kind_r == REC_HIT) && (pos_r == drsd_pkg::PAYLOAD_LAST) && !stopped;
  assign map_rd_addr = full_key[drsd_pkg::MAP_AW-1:0];
  assign hit_req     = hit_req_r;
  assign base_time   = base_r;

endmodule

// ----- hw/rtl/drsd_hit_eval.sv -----
module drsd_hit_eval (
  input  logic                 clk,
  input  logic                 rst_n,
  input  drsd_pkg::hit_req_t   hit_req,
  input  drsd_pkg::map_entry_t map_entry,
  input  logic [63:0]          base_time,
  input  logic                 limit_en,
  input  logic [63:0]          limit_ns,
  output logic                 res_vld,
  output drsd_pkg::result_t    res,
  output logic                 stopped
);

  logic                            s2_vld_r, s3_vld_r, s4_vld_r;
  logic [63:0]                     s2_t_r, s3_t_r, s4_t_r;
  drsd_pkg::map_entry_t            s2_ent_r, s3_ent_r, s4_ent_r;
  logic [drsd_pkg::KEY_W-1:0]      s2_key_r, s3_key_r, s4_key_r;
  logic [19:0]                     s2_pw_r, s3_pw_r, s4_pw_r;
  logic [63:0]                     earliest_r, earliest_nxt;
  logic [63:0]                     s4_lim_r;
  logic                            s4_ovf_r;
  logic                            stopped_r;
  logic [64:0]                     lim_sum;
  logic                            over;

  always_comb begin
    earliest_nxt = earliest_r;
    if (s2_vld_r && s2_ent_r.mapped &&
        (earliest_r == 64'd0 || s2_t_r < earliest_r)) begin
      earliest_nxt = s2_t_r;
    end
  end

  assign lim_sum = {1'b0, earliest_r} + {1'b0, limit_ns};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
      s4_vld_r   <= 1'b0;
      earliest_r <= '0;
      stopped_r  <= 1'b0;
    end else begin
      s2_vld_r   <= hit_req.vld;
      s3_vld_r   <= s2_vld_r;
      s4_vld_r   <= s3_vld_r;
      earliest_r <= earliest_nxt;
      if (s4_vld_r && over) begin
        stopped_r <= 1'b1;
      end
    end
    s2_t_r   <= base_time + {{39{hit_req.diff[24]}}, hit_req.diff};
    s2_ent_r <= map_entry;
    s2_key_r <= hit_req.key;
    s2_pw_r  <= hit_req.pw;
    s3_t_r   <= s2_t_r;
    s3_ent_r <= s2_ent_r;
    s3_key_r <= s2_key_r;
    s3_pw_r  <= s2_pw_r;
    s4_t_r   <= s3_t_r;
    s4_ent_r <= s3_ent_r;
    s4_key_r <= s3_key_r;
    s4_pw_r  <= s3_pw_r;
    s4_lim_r <= lim_sum[63:0];
    s4_ovf_r <= lim_sum[64];
  end

  assign over = limit_en && s4_ent_r.mapped && !s4_ovf_r && (s4_t_r > s4_lim_r);

  always_comb begin
    res.kind          = drsd_pkg::KIND_UNMAPPED;
    res.det_type      = '0;
    res.strip         = '0;
    res.module_id     = s4_key_r[11:8];
    res.channel_key   = s4_key_r;
    res.event_time_ns = '0;
    res.pulse_width   = s4_pw_r;
    if (s4_ent_r.mapped) begin
      res.event_time_ns = s4_t_r;
      if (over) begin
        res.kind = drsd_pkg::KIND_LIMIT;
      end else begin
        res.kind     = drsd_pkg::KIND_MAPPED;
        res.det_type = s4_ent_r.det_type;
        res.strip    = s4_ent_r.strip;
      end
    end
  end

  assign res_vld = s4_vld_r;
  assign stopped = stopped_r;

endmodule

// ----- hw/rtl/detector_record_stream_decoder_unit.sv -----
// Detector record stream decoder.
// Input channel (in_valid / in_stall): one request per cycle while in_stall is
// low. in_opcode selects a raw stream byte (in_byte_value) or a channel map
// write (in_map_*). Time records (0x69) set the base time; once one was seen,
// hit records (0x6a) produce one result each. Output channel (out_valid /
// out_stall): mapped hit, unmapped hit or time limit reached. Config port:
// cfg_write_en, cfg_index, cfg_data, no handshake. Throughput: one request per
// cycle while in_stall is low. A result reaches out_* through stages: the map
// read shares the edge that takes the last byte of its hit record, then time
// add, earliest-time update, limit sum and limit compare take one stage each.
// Reset: the 4096-entry channel map is swept to zero, one entry per cycle, so
// in_stall stays high until the sweep ends; config writes are taken.
// Output stall: results sit in the output register. Stream bytes keep flowing;
// only the last byte of a hit record is held off while an earlier result is
// still waiting and stalled. After a time limit result all stream bytes are
// dropped until reset.
module detector_record_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_byte_value,
  input  logic [11:0] in_map_key,
  input  logic        in_map_valid,
  input  logic [1:0]  in_map_type,
  input  logic [7:0]  in_map_strip,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [1:0]  out_det_type,
  output logic [7:0]  out_strip,
  output logic [3:0]  out_module_id,
  output logic [11:0] out_channel_key,
  output logic [63:0] out_event_time_ns,
  output logic [19:0] out_pulse_width,

  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  logic                        limit_en_r;
  logic [63:0]                 limit_ns_r;
  logic                        out_valid_r;
  drsd_pkg::result_t           out_res_r;

  logic                        in_acc;
  logic                        byte_acc;
  logic                        map_wr;
  logic                        hit_last;
  logic                        stopped;
  logic                        clearing;
  logic [drsd_pkg::MAP_AW-1:0] map_rd_addr;
  drsd_pkg::map_entry_t        wr_entry;
  drsd_pkg::map_entry_t        rd_entry;
  drsd_pkg::hit_req_t          hit_req;
  logic [63:0]                 base_time;
  logic                        res_vld;
  drsd_pkg::result_t           res;

  assign in_stall = clearing || (hit_last && out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign byte_acc = in_acc && (in_opcode == drsd_pkg::OP_BYTE) && !stopped;
  assign map_wr   = in_acc && (in_opcode == drsd_pkg::OP_MAP);

  assign wr_entry.mapped   = in_map_valid;
  assign wr_entry.det_type = in_map_type;
  assign wr_entry.strip    = in_map_strip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_en_r <= 1'b0;
      limit_ns_r <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        drsd_pkg::CFG_LIMIT_EN: limit_en_r <= cfg_data[0];
        drsd_pkg::CFG_LIMIT_NS: limit_ns_r <= cfg_data;
        default: ;
      endcase
    end
  end

  drsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_acc    (byte_acc),
    .byte_value  (in_byte_value),
    .stopped     (stopped),
    .hit_last    (hit_last),
    .map_rd_addr (map_rd_addr),
    .hit_req     (hit_req),
    .base_time   (base_time)
  );

  drsd_chan_map u_chan_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (map_wr),
    .wr_addr  (in_map_key[drsd_pkg::MAP_AW-1:0]),
    .wr_entry (wr_entry),
    .rd_addr  (map_rd_addr),
    .rd_entry (rd_entry),
    .clearing (clearing)
  );

  drsd_hit_eval u_hit_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .hit_req   (hit_req),
    .map_entry (rd_entry),
    .base_time (base_time),
    .limit_en  (limit_en_r),
    .limit_ns  (limit_ns_r),
    .res_vld   (res_vld),
    .res       (res),
    .stopped   (stopped)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_vld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_res_r.kind;
  assign out_det_type      = out_res_r.det_type;
  assign out_strip         = out_res_r.strip;
  assign out_module_id     = out_res_r.module_id;
  assign out_channel_key   = out_res_r.channel_key;
  assign out_event_time_ns = out_res_r.event_time_ns;
  assign out_pulse_width   = out_res_r.pulse_width;

  // a new result never lands on one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> !(out_valid_r && out_stall))
    else $error("result overwrote a stalled result");

  // no hit request enters once stopped
  a_stop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    stopped |-> !hit_req.vld)
    else $error("hit request after stop");

  // stop comes with a limit result
  a_stop_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stopped) |-> out_valid_r && out_res_r.kind == drsd_pkg::KIND_LIMIT)
    else $error("stop without limit result");

  a_limit_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind == drsd_pkg::KIND_LIMIT) |-> limit_en_r)
    else $error("limit result with limit disabled");

endmodule
